### design/q24_8_fixed_point_alu_assert.svh
// Assertion macros for the Q24.8 arithmetic unit.
// Used by modules that hold clk and arst_n in scope.
`ifndef Q24_8_FIXED_POINT_ALU_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_ASSERT_SVH

// same-cycle implication
`define Q24_CHK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define Q24_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/q24alu_pkg.sv
// Shared types and command codes for the Q24.8 arithmetic unit.
// No dependencies.
package q24alu_pkg;

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_SUB   = 4'd1,
		CMD_MUL   = 4'd2,
		CMD_DIV   = 4'd3,
		CMD_CMP   = 4'd4,
		CMD_MIN   = 4'd5,
		CMD_MAX   = 4'd6,
		CMD_INC   = 4'd7,
		CMD_DEC   = 4'd8,
		CMD_FINT  = 4'd9,
		CMD_FFLT  = 4'd10,
		CMD_TFLT  = 4'd11,
		CMD_TINT  = 4'd12
	} cmd_t;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [31:0] res;
		logic        gt;
		logic        lt;
		logic        eq;
		logic        dz;
		logic        neg;
		logic [63:0] prod;
		logic [31:0] fmag;
		logic [4:0]  fpos;
	} payload_t;

endpackage

### design/q24_8_fixed_point_alu.sv
// Q24.8 fixed-point arithmetic unit, top level.
// Depends on q24alu_pkg, q24alu_front, q24alu_div_cell, q24alu_back and q24_8_fixed_point_alu_assert.svh.
//
// A request enters on in_valid with cmd and operands; it is taken when
// in_valid is high and in_stall low. One result leaves on out_valid and is
// taken when out_stall is low. Every request gives exactly one result.
// The pipeline has one input stage, a row of 32 + FRACTION_BITS division
// cells (one quotient bit each), and an output register. All operations
// travel the same row, so results come back in request order. It takes
// one request per cycle while no result is held by out_stall.
// When a result is held by out_stall the whole pipeline holds and in_stall
// rises in the same cycle; it falls as soon as the result is taken.
// Reset clears all valid flags; the data registers are not reset.
`include "q24_8_fixed_point_alu_assert.svh"
module q24_8_fixed_point_alu #(
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         cmd,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic signed [23:0] int_value,
	input  logic [31:0]        float_bits,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result,
	output logic [31:0]        float_result,
	output logic               greater,
	output logic               less,
	output logic               equal,
	output logic               div_by_zero
);

	localparam int W = 32 + FRACTION_BITS;

	logic                 en;
	logic                 v_w   [0:W];
	q24alu_pkg::payload_t pl_w  [0:W];
	logic [31:0]          rem_w [0:W];
	logic [W-1:0]         nq_w  [0:W];
	logic [31:0]          d_w   [0:W];

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign rem_w[0] = '0;

	q24alu_front #(.FRACTION_BITS(FRACTION_BITS), .W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.int_value(int_value), .float_bits(float_bits),
		.v_s1(v_w[0]), .pl_s1(pl_w[0]), .nq_s1(nq_w[0]), .d_s1(d_w[0])
	);

	for (genvar i = 0; i < W; i++) begin : g_cell
		q24alu_div_cell #(.W(W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(v_w[i]), .pl_in(pl_w[i]), .rem_in(rem_w[i]),
			.nq_in(nq_w[i]), .d_in(d_w[i]),
			.v_s1(v_w[i+1]), .pl_s1(pl_w[i+1]), .rem_s1(rem_w[i+1]),
			.nq_s1(nq_w[i+1]), .d_s1(d_w[i+1])
		);
	end

	q24alu_back #(.FRACTION_BITS(FRACTION_BITS), .W(W)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_w[W]), .pl_in(pl_w[W]),
		.q_in(nq_w[W]), .out_valid(out_valid), .result(result),
		.float_result(float_result), .greater(greater), .less(less),
		.equal(equal), .div_by_zero(div_by_zero)
	);

	`Q24_CHK(a_cmp_onehot, out_valid, $onehot0({greater, less, equal}), "compare flags not exclusive")
	`Q24_CHK(a_cmp_zero, out_valid && (greater || less || equal), result == 32'sd0 && float_result == 32'd0, "compare result not zero")
	`Q24_CHK(a_dz_zero, out_valid && div_by_zero, result == 32'sd0, "divide by zero result not zero")
	`Q24_CHK(a_stall_src, in_stall, out_valid && out_stall, "input held without output hold")
	`Q24_CHK_NEXT(a_advance, v_w[W] && en, out_valid, "last cell result lost")

endmodule

### design/q24alu_front.sv
// Input stage: simple operations, float decode, product and divider setup.
// Depends on q24alu_pkg.
module q24alu_front #(
	parameter int FRACTION_BITS = 8,
	parameter int W = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [3:0]           cmd,
	input  logic signed [31:0]   operand_a,
	input  logic signed [31:0]   operand_b,
	input  logic signed [23:0]   int_value,
	input  logic [31:0]          float_bits,
	output logic                 v_s1,
	output q24alu_pkg::payload_t pl_s1,
	output logic [W-1:0]         nq_s1,
	output logic [31:0]          d_s1
);

	logic [31:0] ma, mb, iv_ext, ff_res, ff_mag, limit;
	logic        a_le_b, a_ge_b, fneg;
	logic [7:0]  ex;
	logic [23:0] man;
	logic signed [9:0] e;
	logic [4:0]  s;
	logic [55:0] shl;
	logic [25:0] rnd;
	logic [4:0]  pos;
	q24alu_pkg::payload_t pl;

	always_comb begin
		ma = operand_a[31] ? (32'd0 - operand_a) : operand_a;
		mb = operand_b[31] ? (32'd0 - operand_b) : operand_b;
		a_le_b = operand_a <= operand_b;
		a_ge_b = operand_a >= operand_b;
		iv_ext = {{8{int_value[23]}}, int_value};

		fneg = float_bits[31];
		ex = float_bits[30:23];
		man = {(ex != 8'd0), float_bits[22:0]};
		limit = fneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		e = ((ex == 8'd0) ? 10'sd1 : $signed({2'b00, ex})) - 10'sd150
			+ 10'(FRACTION_BITS);
		s = 5'd0;
		shl = '0;
		rnd = '0;
		ff_mag = '0;
		if (ex == 8'hFF) begin
			ff_mag = (man[22:0] != 23'd0) ? 32'd0 : limit;
		end else if (e >= 10'sd0) begin
			if (e >= 10'sd32) begin
				ff_mag = (man != 24'd0) ? limit : 32'd0;
			end else begin
				shl = {32'd0, man} << e[4:0];
				ff_mag = (shl > {24'd0, limit}) ? limit : shl[31:0];
			end
		end else if (e > -10'sd25) begin
			s = 5'(-e);
			rnd = ({2'b00, man} + (26'd1 << (s - 5'd1))) >> s;
			ff_mag = {6'd0, rnd};
		end
		ff_res = fneg ? (32'd0 - ff_mag) : ff_mag;

		pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (ma[i]) begin
				pos = 5'(i);
			end
		end

		pl = '0;
		pl.cmd = cmd;
		pl.neg = operand_a[31] ^ operand_b[31];
		pl.prod = {32'd0, ma} * {32'd0, mb};
		pl.fmag = ma;
		pl.fpos = pos;
		case (cmd)
			q24alu_pkg::CMD_ADD:  pl.res = operand_a + operand_b;
			q24alu_pkg::CMD_SUB:  pl.res = operand_a - operand_b;
			q24alu_pkg::CMD_DIV:  pl.dz = (operand_b == 32'sd0);
			q24alu_pkg::CMD_CMP: begin
				pl.gt = !a_le_b;
				pl.lt = !a_ge_b;
				pl.eq = operand_a == operand_b;
			end
			q24alu_pkg::CMD_MIN:  pl.res = a_le_b ? operand_a : operand_b;
			q24alu_pkg::CMD_MAX:  pl.res = a_ge_b ? operand_a : operand_b;
			q24alu_pkg::CMD_INC:  pl.res = operand_a + 32'sd1;
			q24alu_pkg::CMD_DEC:  pl.res = operand_a - 32'sd1;
			q24alu_pkg::CMD_FINT: pl.res = iv_ext << FRACTION_BITS;
			q24alu_pkg::CMD_FFLT: pl.res = ff_res;
			q24alu_pkg::CMD_TFLT: pl.neg = operand_a[31];
			q24alu_pkg::CMD_TINT: pl.res = operand_a >>> FRACTION_BITS;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= pl;
			nq_s1 <= {{FRACTION_BITS{1'b0}}, ma} << FRACTION_BITS;
			d_s1 <= mb;
		end
	end

endmodule

### design/q24alu_div_cell.sv
// One restoring-division cell: produces one quotient bit per stage.
// Depends on q24alu_pkg.
module q24alu_div_cell #(
	parameter int W = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  q24alu_pkg::payload_t pl_in,
	input  logic [31:0]          rem_in,
	input  logic [W-1:0]         nq_in,
	input  logic [31:0]          d_in,
	output logic                 v_s1,
	output q24alu_pkg::payload_t pl_s1,
	output logic [31:0]          rem_s1,
	output logic [W-1:0]         nq_s1,
	output logic [31:0]          d_s1
);

	logic [32:0] t;
	logic        ge;

	assign t = {rem_in, nq_in[W-1]};
	assign ge = t >= {1'b0, d_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= pl_in;
			d_s1 <= d_in;
			rem_s1 <= ge ? 32'(t - {1'b0, d_in}) : t[31:0];
			nq_s1 <= {nq_in[W-2:0], ge};
		end
	end

endmodule

### design/q24alu_back.sv
// Output stage: multiply rounding, divide sign, fixed-to-float, result select.
// Depends on q24alu_pkg.
module q24alu_back #(
	parameter int FRACTION_BITS = 8,
	parameter int W = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  q24alu_pkg::payload_t pl_in,
	input  logic [W-1:0]         q_in,
	output logic                 out_valid,
	output logic signed [31:0]   result,
	output logic [31:0]          float_result,
	output logic                 greater,
	output logic                 less,
	output logic                 equal,
	output logic                 div_by_zero
);

	localparam int EXP_OFS = 127 - FRACTION_BITS;

	logic [63:0] prnd;
	logic [31:0] mmag, res, fres;
	logic [24:0] m;
	logic [31:0] remm, half, sh;
	logic [5:0]  pp;
	logic [3:0]  s;
	logic [8:0]  ex9;

	always_comb begin
		prnd = (pl_in.prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		mmag = prnd[31:0];

		pp = {1'b0, pl_in.fpos};
		s = '0;
		remm = '0;
		half = '0;
		if (pl_in.fpos <= 5'd23) begin
			sh = pl_in.fmag << (5'd23 - pl_in.fpos);
			m = {1'b0, sh[23:0]};
		end else begin
			s = 4'(pl_in.fpos - 5'd23);
			sh = pl_in.fmag >> s;
			m = sh[24:0];
			remm = pl_in.fmag & ((32'd1 << s) - 32'd1);
			half = 32'd1 << (s - 4'd1);
			if (remm > half || (remm == half && m[0])) begin
				m = m + 25'd1;
			end
			if (m[24]) begin
				m = m >> 1;
				pp = pp + 6'd1;
			end
		end
		ex9 = {3'd0, pp} + 9'(EXP_OFS);
		fres = (pl_in.fmag == 32'd0) ? 32'd0 : {pl_in.neg, ex9[7:0], m[22:0]};

		res = pl_in.res;
		case (pl_in.cmd)
			q24alu_pkg::CMD_MUL: res = pl_in.neg ? (32'd0 - mmag) : mmag;
			q24alu_pkg::CMD_DIV: res = pl_in.dz ? 32'd0
				: (pl_in.neg ? (32'd0 - q_in[31:0]) : q_in[31:0]);
			default: ;
		endcase
		if (pl_in.cmd != q24alu_pkg::CMD_TFLT) begin
			fres = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= res;
			float_result <= fres;
			greater <= pl_in.gt;
			less <= pl_in.lt;
			equal <= pl_in.eq;
			div_by_zero <= pl_in.dz;
		end
	end

endmodule
